// ===== rtl/mrc4_pkg.sv =====
// Shared types, constants and the microcode table of the modified RC4 core.
// Depends on nothing; the sequencer, the top level and both testbench files import it.
package mrc4_pkg;

  // Key store and permutation sizes
  localparam int KEY_DEPTH  = 64;
  localparam int KEY_AW     = $clog2(KEY_DEPTH);
  localparam int PERM_DEPTH = 256;

  // Configuration reset values
  localparam logic [6:0]  KEYLEN_RESET  = 7'd1;
  localparam logic [11:0] DISCARD_RESET = 12'd1013;

  // Configuration register index (paddr[2])
  localparam logic REG_KEY_LENGTH = 1'b0;
  localparam logic REG_DISCARD    = 1'b1;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_KEY  = 2'd0,
    FUNC_PREP = 2'd1,
    FUNC_DATA = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // Microcode steps
  typedef enum logic [4:0] {
    S_IDLE  = 5'd0,
    S_KEYW  = 5'd1,
    S_PINIT = 5'd2,
    S_FILL  = 5'd3,
    S_K0    = 5'd4,
    S_KM    = 5'd5,
    S_KK    = 5'd6,
    S_KJ    = 5'd7,
    S_KR    = 5'd8,
    S_KW1   = 5'd9,
    S_KW2   = 5'd10,
    S_DINIT = 5'd11,
    S_DZ    = 5'd12,
    S_DA    = 5'd13,
    S_DB    = 5'd14,
    S_DC    = 5'd15,
    S_DD    = 5'd16,
    S_EMIT  = 5'd17,
    S_EA    = 5'd18,
    S_EB    = 5'd19,
    S_EC    = 5'd20,
    S_ED    = 5'd21
  } step_t;

  // Permutation read address source
  typedef enum logic [2:0] {
    RA_J    = 3'd0,
    RA_I    = 3'd1,
    RA_X1   = 3'd2,
    RA_YSQ  = 3'd3,
    RA_TATB = 3'd4
  } ra_sel_t;

  // Permutation write address source
  typedef enum logic [1:0] {
    WA_I = 2'd0,
    WA_J = 2'd1,
    WA_X = 2'd2,
    WA_Y = 2'd3
  } wa_sel_t;

  // Permutation write data source
  typedef enum logic [1:0] {
    WD_I  = 2'd0,
    WD_SQ = 2'd1,
    WD_TA = 2'd2
  } wd_sel_t;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,  // fall through
    C_GOTO      = 3'd1,  // unconditional jump
    C_I_MORE    = 3'd2,  // jump while i has not reached 255
    C_BCNT_MORE = 3'd3,  // jump while remainder bits remain
    C_DCNT_ZERO = 3'd4,  // jump when nothing to discard
    C_DCNT_MORE = 3'd5,  // jump while more than one discard left
    C_DISPATCH  = 3'd6,  // wait for a request, branch on its function
    C_OUT_WAIT  = 3'd7   // hold until the result register is free
  } cond_t;

  // One control word
  typedef struct packed {
    logic    idle;
    logic    s_ren;
    ra_sel_t ra;
    logic    s_we;
    wa_sel_t wa;
    wd_sel_t wd;
    logic    key_we;
    logic    key_ren;
    logic    clr_ij;
    logic    inc_i;
    logic    rem_clr;
    logic    mod_step;
    logic    ld_ta;
    logic    ld_tb;
    logic    ld_j;
    logic    ld_y;
    logic    inc_x;
    logic    clr_xy;
    logic    ld_dcnt;
    logic    dec_dcnt;
    logic    out_ld;
    cond_t   cond;
    step_t   target;
  } ucw_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic  accept;
    func_t func;
    logic  i_last;
    logic  bcnt_zero;
    logic  dcnt_zero;
    logic  dcnt_one;
    logic  out_busy;
  } stat_t;

  // Microcode ROM
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.idle = 1'b1;
        w.cond = C_DISPATCH;
      end
      S_KEYW: begin
        w.key_we = 1'b1;
        w.cond   = C_GOTO;
        w.target = S_EMIT;
      end
      S_PINIT: begin
        w.clr_ij = 1'b1;
      end
      // identity fill
      S_FILL: begin
        w.s_we   = 1'b1;
        w.wa     = WA_I;
        w.wd     = WD_I;
        w.inc_i  = 1'b1;
        w.cond   = C_I_MORE;
        w.target = S_FILL;
      end
      // schedule step: read S[j], start remainder j mod len
      S_K0: begin
        w.s_ren   = 1'b1;
        w.ra      = RA_J;
        w.rem_clr = 1'b1;
      end
      S_KM: begin
        w.mod_step = 1'b1;
        w.cond     = C_BCNT_MORE;
        w.target   = S_KM;
      end
      S_KK: begin
        w.key_ren = 1'b1;
        w.ld_tb   = 1'b1;
      end
      S_KJ: begin
        w.ld_j  = 1'b1;
        w.s_ren = 1'b1;
        w.ra    = RA_I;
      end
      S_KR: begin
        w.s_ren = 1'b1;
        w.ra    = RA_J;
        w.ld_ta = 1'b1;
      end
      S_KW1: begin
        w.s_we = 1'b1;
        w.wa   = WA_I;
        w.wd   = WD_SQ;
      end
      S_KW2: begin
        w.s_we   = 1'b1;
        w.wa     = WA_J;
        w.wd     = WD_TA;
        w.inc_i  = 1'b1;
        w.cond   = C_I_MORE;
        w.target = S_K0;
      end
      // keystream drop
      S_DINIT: begin
        w.clr_xy  = 1'b1;
        w.ld_dcnt = 1'b1;
      end
      S_DZ: begin
        w.cond   = C_DCNT_ZERO;
        w.target = S_EMIT;
      end
      S_DA, S_EA: begin
        w.inc_x = 1'b1;
        w.s_ren = 1'b1;
        w.ra    = RA_X1;
      end
      S_DB, S_EB: begin
        w.ld_ta = 1'b1;
        w.ld_y  = 1'b1;
        w.s_ren = 1'b1;
        w.ra    = RA_YSQ;
      end
      S_DC, S_EC: begin
        w.ld_tb = 1'b1;
        w.s_we  = 1'b1;
        w.wa    = WA_X;
        w.wd    = WD_SQ;
      end
      S_DD: begin
        w.s_we     = 1'b1;
        w.wa       = WA_Y;
        w.wd       = WD_TA;
        w.dec_dcnt = 1'b1;
        w.cond     = C_DCNT_MORE;
        w.target   = S_DA;
      end
      S_EMIT: begin
        w.out_ld = 1'b1;
        w.cond   = C_OUT_WAIT;
        w.target = S_IDLE;
      end
      // data byte: swap write plus keystream read
      S_ED: begin
        w.s_we   = 1'b1;
        w.wa     = WA_Y;
        w.wd     = WD_TA;
        w.s_ren  = 1'b1;
        w.ra     = RA_TATB;
        w.cond   = C_GOTO;
        w.target = S_EMIT;
      end
      default: begin
        w.cond   = C_GOTO;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mrc4_if.sv =====
// Request and result channel interfaces of the modified RC4 core.
// Depends on nothing; field widths follow the channel definitions.
interface mrc4_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [5:0] key_index;
  logic [7:0] in_value;
  logic       last_byte;

  modport source (output valid, func, key_index, in_value, last_byte, input ready);
  modport sink   (input valid, func, key_index, in_value, last_byte, output ready);
endinterface

interface mrc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, out_byte, out_last, input ready);
  modport sink   (input valid, out_byte, out_last, output ready);
endinterface

// ===== rtl/mrc4_useq.sv =====
// Microcode sequencer: step counter, control ROM lookup and branch logic.
// Depends on mrc4_pkg (step_t, ucw_t, stat_t, ucode).
module mrc4_useq import mrc4_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ucw_t  cw
);

  step_t pc;
  step_t pc_next;

  assign cw = ucode(pc);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Branch selection
  always_comb begin
    pc_next = step_t'(5'(pc + 5'd1));
    case (cw.cond)
      C_NEXT: begin
        pc_next = step_t'(5'(pc + 5'd1));
      end
      C_GOTO: begin
        pc_next = cw.target;
      end
      C_I_MORE: begin
        if (!stat.i_last) pc_next = cw.target;
      end
      C_BCNT_MORE: begin
        if (!stat.bcnt_zero) pc_next = cw.target;
      end
      C_DCNT_ZERO: begin
        if (stat.dcnt_zero) pc_next = cw.target;
      end
      C_DCNT_MORE: begin
        if (!stat.dcnt_one) pc_next = cw.target;
      end
      C_DISPATCH: begin
        pc_next = pc;
        if (stat.accept) begin
          case (stat.func)
            FUNC_KEY:  pc_next = S_KEYW;
            FUNC_PREP: pc_next = S_PINIT;
            FUNC_DATA: pc_next = S_EA;
            default:   pc_next = S_EMIT;
          endcase
        end
      end
      C_OUT_WAIT: begin
        pc_next = stat.out_busy ? pc : cw.target;
      end
      default: begin
        pc_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/modified_rc4_stream_cipher_core.sv =====
// Top level of the modified RC4 core: config registers, datapath, memories.
// Depends on mrc4_pkg, mrc4_if (channels) and mrc4_useq (sequencer).
//
//  channel   | kind          | payload
//  ----------+---------------+------------------------------------------
//  data_in   | valid/ready   | func, key_index, in_value, last_byte
//  data_out  | valid/ready   | out_byte, out_last
//  apb       | psel/penable  | paddr[2:0], pwdata/prdata 32 bits
//
// One request at a time. Key load runs KEYW then EMIT, function 3 goes
// straight to EMIT, and a data byte runs EA to ED then EMIT, its steps set
// by one read and one write port on the permutation memory. Prepare grows
// with discard_count and is dominated by the bit-serial key index remainder.
// A finished result sits in the output register while the next request
// is taken; it stalls the core only if still untaken at the next result.
// Synchronous reset returns to idle; permutation and key store keep contents.
module modified_rc4_stream_cipher_core import mrc4_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  mrc4_in_if.sink           data_in,
  mrc4_out_if.source        data_out,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers
  logic [6:0]  key_length;
  logic [11:0] discard_count;

  // Captured request
  func_t             item_func;
  logic [KEY_AW-1:0] item_kidx;
  logic [7:0]        item_val;
  logic              item_last;

  // Datapath registers
  logic [7:0]  i, j, x, y, ta, tb, sq, kq;
  logic [5:0]  rem;
  logic [2:0]  bcnt;
  logic [11:0] dcnt;

  // Result register
  logic        out_valid;
  logic [7:0]  res_byte;
  logic        res_last;

  // Memories
  logic [7:0] perm_mem [PERM_DEPTH];
  logic [7:0] key_mem  [KEY_DEPTH];

  ucw_t  cw;
  stat_t stat;

  logic        accept;
  logic        out_busy;
  logic        emit;
  logic [6:0]  klen_eff;
  logic [6:0]  rem_shift;
  logic [6:0]  rem_sub;
  logic [7:0]  raddr, waddr, wdata;
  logic        kidx_ok;

  mrc4_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw)
  );

  // Handshakes
  assign accept        = data_in.valid & cw.idle;
  assign data_in.ready = cw.idle;
  assign out_busy      = out_valid & ~data_out.ready;
  assign emit          = cw.out_ld & ~out_busy;

  assign stat.accept    = accept;
  assign stat.func      = func_t'(data_in.func);
  assign stat.i_last    = (i == 8'hFF);
  assign stat.bcnt_zero = (bcnt == 3'd0);
  assign stat.dcnt_zero = (dcnt == 12'd0);
  assign stat.dcnt_one  = (dcnt == 12'd1);
  assign stat.out_busy  = out_busy;

  // APB register port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_KEY_LENGTH: prdata = {25'd0, key_length};
      REG_DISCARD:    prdata = {20'd0, discard_count};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length    <= KEYLEN_RESET;
      discard_count <= DISCARD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_KEY_LENGTH: key_length    <= pwdata[6:0];
        REG_DISCARD:    discard_count <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Effective key length: zero means one, saturate at the store size
  always_comb begin
    if (key_length == 7'd0) begin
      klen_eff = 7'd1;
    end else if (key_length > 7'(KEY_DEPTH)) begin
      klen_eff = 7'(KEY_DEPTH);
    end else begin
      klen_eff = key_length;
    end
  end

  // Restoring remainder step, one bit of j per cycle
  assign rem_shift = {rem, j[bcnt]};
  assign rem_sub   = rem_shift - klen_eff;

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      item_func <= func_t'(data_in.func);
      item_kidx <= data_in.key_index;
      item_val  <= data_in.in_value;
      item_last <= data_in.last_byte;
    end
  end

  // Permutation address and data selection
  always_comb begin
    case (cw.ra)
      RA_J:    raddr = j;
      RA_I:    raddr = i;
      RA_X1:   raddr = 8'(x + 8'd1);
      RA_YSQ:  raddr = 8'(y + sq);
      RA_TATB: raddr = 8'(ta + tb);
      default: raddr = j;
    endcase
  end

  always_comb begin
    case (cw.wa)
      WA_I:    waddr = i;
      WA_J:    waddr = j;
      WA_X:    waddr = x;
      WA_Y:    waddr = y;
      default: waddr = i;
    endcase
  end

  always_comb begin
    case (cw.wd)
      WD_I:    wdata = i;
      WD_SQ:   wdata = sq;
      WD_TA:   wdata = ta;
      default: wdata = sq;
    endcase
  end

  // Permutation memory: one write, one registered read with write bypass
  always_ff @(posedge clk) begin
    if (cw.s_we) begin
      perm_mem[waddr] <= wdata;
    end
    if (cw.s_ren) begin
      sq <= (cw.s_we && (waddr == raddr)) ? wdata : perm_mem[raddr];
    end
  end

  // Key store
  assign kidx_ok = ({1'b0, item_kidx} < 7'(KEY_DEPTH));
  always_ff @(posedge clk) begin
    if (cw.key_we && kidx_ok) begin
      key_mem[item_kidx] <= item_val;
    end
    if (cw.key_ren) begin
      kq <= key_mem[rem[KEY_AW-1:0]];
    end
  end

  // Index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x <= 8'd0;
      y <= 8'd0;
    end else begin
      if (cw.clr_xy) begin
        x <= 8'd0;
        y <= 8'd0;
      end else begin
        if (cw.inc_x) x <= 8'(x + 8'd1);
        if (cw.ld_y)  y <= 8'(y + sq);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.clr_ij) begin
      i <= 8'd0;
      j <= 8'd0;
    end else begin
      if (cw.inc_i) i <= 8'(i + 8'd1);
      if (cw.ld_j)  j <= 8'(kq + tb + j);
    end
  end

  // Temporaries and remainder unit
  always_ff @(posedge clk) begin
    if (cw.ld_ta) ta <= sq;
    if (cw.ld_tb) tb <= sq;
    if (cw.rem_clr) begin
      rem  <= 6'd0;
      bcnt <= 3'd7;
    end else if (cw.mod_step) begin
      rem  <= (rem_shift >= klen_eff) ? rem_sub[5:0] : rem_shift[5:0];
      bcnt <= 3'(bcnt - 3'd1);
    end
  end

  // Discard counter
  always_ff @(posedge clk) begin
    if (cw.ld_dcnt) begin
      dcnt <= discard_count;
    end else if (cw.dec_dcnt) begin
      dcnt <= 12'(dcnt - 12'd1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (data_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_byte <= (item_func == FUNC_DATA) ? (item_val ^ sq) : 8'd0;
      res_last <= item_last;
    end
  end

  assign data_out.valid    = out_valid;
  assign data_out.out_byte = res_byte;
  assign data_out.out_last = res_last;

endmodule

// ===== rtl/mrc4_chk.sv =====
// Port-level checker for the modified RC4 core, attached by bind.
// Depends on the top level's channel ports only.
module mrc4_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Requests taken but not yet delivered
  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= 2'(pending + {1'b0, in_acc} - {1'b0, out_acc});
    end
  end

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // One request at a time: busy right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("second request taken while busy");

  // No result without a request behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without request");

  // At most one in work plus one waiting in the result register
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many requests in flight");

  // Reset leaves the core idle with no result
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind modified_rc4_stream_cipher_core mrc4_chk u_mrc4_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (data_in.valid),
  .in_ready  (data_in.ready),
  .out_valid (data_out.valid),
  .out_ready (data_out.ready),
  .out_byte  (data_out.out_byte),
  .out_last  (data_out.out_last)
);

// ===== tb/sv/mrc4_cipher_checker.sv =====
// Passive checker for the modified RC4 core: tracks the cipher state,
// predicts one result per request and compares it. Depends on mrc4_pkg
// and the request/result channel interfaces in mrc4_if.
module mrc4_cipher_checker import mrc4_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mrc4_in_if          req_ch,
  mrc4_out_if         res_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last;
  } cipher_result_t;

  cipher_result_t expected_results[$];

  // Cipher state mirror
  logic [7:0]  sbox [PERM_DEPTH];
  logic [7:0]  key_bytes [KEY_DEPTH];
  logic [7:0]  ks_x, ks_y;
  logic [6:0]  key_len_cfg;
  logic [11:0] drop_cfg;

  int error_tally = 0;
  int pending_cnt = 0;

  assign mismatches  = error_tally;
  assign outstanding = pending_cnt;

  task automatic report_error(input string field, input logic [7:0] got,
                              input logic [7:0] want);
    $display("ERROR %0t: %s got %02h expected %02h", $realtime, field, got, want);
    error_tally++;
  endtask

  // One RC4 output step; swaps two entries and returns the keystream byte
  function automatic logic [7:0] next_keystream();
    logic [7:0] tx, ty, sum;
    ks_x = ks_x + 8'd1;
    tx = sbox[ks_x];
    ks_y = ks_y + tx;
    ty = sbox[ks_y];
    sbox[ks_x] = ty;
    sbox[ks_y] = tx;
    sum = tx + ty;
    return sbox[sum];
  endfunction

  // Identity fill, modified key schedule, then keystream drop
  task automatic run_key_schedule();
    int unsigned eff_len;
    int          n;
    logic [7:0]  j, tmp, dropped;
    eff_len = (key_len_cfg == 7'd0) ? 1 :
              (key_len_cfg > KEY_DEPTH) ? KEY_DEPTH : key_len_cfg;
    for (n = 0; n < PERM_DEPTH; n++) sbox[n] = n[7:0];
    j = 8'd0;
    for (n = 0; n < PERM_DEPTH; n++) begin
      j = key_bytes[j % eff_len] + sbox[j] + j;
      tmp = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = tmp;
    end
    ks_x = 8'd0;
    ks_y = 8'd0;
    for (n = 0; n < drop_cfg; n++) dropped = next_keystream();
  endtask

  always @(posedge clk) begin : watch
    cipher_result_t got, want;
    if (rst) begin
      key_len_cfg = KEYLEN_RESET;
      drop_cfg    = DISCARD_RESET;
      ks_x        = 8'd0;
      ks_y        = 8'd0;
      expected_results.delete();
    end else begin
      // result side first: a request taken at this edge cannot be answered yet
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.out_byte, res_ch.out_last};
        if (expected_results.size() == 0) begin
          report_error("unexpected result, out_byte", got.cipher_byte, 8'h00);
        end else begin
          want = expected_results.pop_front();
          if (got.cipher_byte !== want.cipher_byte)
            report_error("out_byte", got.cipher_byte, want.cipher_byte);
          if (got.last !== want.last)
            report_error("out_last", {7'd0, got.last}, {7'd0, want.last});
        end
      end
      // request side: update the mirror and queue the expected result
      if (req_ch.valid && req_ch.ready) begin
        want = '{8'h00, req_ch.last_byte};
        case (func_t'(req_ch.func))
          FUNC_KEY:  key_bytes[req_ch.key_index] = req_ch.in_value;
          FUNC_PREP: run_key_schedule();
          FUNC_DATA: want.cipher_byte = req_ch.in_value ^ next_keystream();
          default: ;
        endcase
        expected_results.push_back(want);
      end
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_KEY_LENGTH) key_len_cfg = pwdata[6:0];
        else drop_cfg = pwdata[11:0];
      end
    end
    pending_cnt = expected_results.size();
  end

endmodule

// ===== tb/sv/modified_rc4_stream_cipher_core_test.sv =====
// Top of the modified RC4 core test: clock, reset, request and result
// traffic, register writes and the verdict. Depends on mrc4_pkg, mrc4_if,
// the core and mrc4_cipher_checker.
module modified_rc4_stream_cipher_core_test;
  import mrc4_pkg::*;

  localparam longint CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  mrc4_in_if  req_ch ();
  mrc4_out_if res_ch ();

  int         mismatches, outstanding;
  longint     cycle_count = 0;
  int         sent_requests = 0;
  logic [63:0] key_loaded;
  logic [6:0] key_len_now;
  bit         send_gaps = 1'b1;
  bit         take_stalls = 1'b1;

  modified_rc4_stream_cipher_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .data_in  (req_ch),
    .data_out (res_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mrc4_cipher_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req_ch      (req_ch),
    .res_ch      (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one request after a random gap, hold it until taken
  task automatic send_request(input func_t f, input logic [5:0] idx,
                              input logic [7:0] val, input logic last);
    int gap;
    if ($urandom_range(0, 39) == 0) send_gaps = !send_gaps;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.key_index <= idx;
    req_ch.in_value  <= val;
    req_ch.last_byte <= last;
    do @(posedge clk); while (!req_ch.ready);
    if (f == FUNC_KEY) key_loaded[idx] = 1'b1;
    sent_requests++;
  endtask

  // Stop requests and wait until every result has been taken
  task automatic drain_requests();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
  endtask

  // Two-phase register write; the bus returns to idle after the access phase
  task automatic write_register(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_KEY_LENGTH) key_len_now = value[6:0];
  endtask

  // Load any key byte the schedule will read that was never written, then prepare
  task automatic rekey_and_prepare();
    int eff_len;
    int k;
    eff_len = (key_len_now == 7'd0) ? 1 :
              (key_len_now > KEY_DEPTH) ? KEY_DEPTH : key_len_now;
    for (k = 0; k < eff_len; k++)
      if (!key_loaded[k])
        send_request(FUNC_KEY, k[5:0], 8'($urandom), 1'($urandom));
    send_request(FUNC_PREP, 6'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // One random sequence: mostly messages, some rekeying, some noise
  task automatic random_burst();
    int pick, len, k;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = $urandom_range(1, 16);
      for (k = 0; k < len; k++)
        send_request(FUNC_DATA, 6'($urandom), 8'($urandom), k == len - 1);
    end else if (pick < 80) begin
      len = $urandom_range(1, 8);
      for (k = 0; k < len; k++)
        send_request(FUNC_KEY, 6'($urandom), 8'($urandom), 1'($urandom));
      rekey_and_prepare();
    end else if (pick < 88) begin
      send_request(FUNC_KEY, 6'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 94) begin
      send_request(FUNC_NONE, 6'($urandom), 8'($urandom), 1'($urandom));
    end else if (pick < 97) begin
      send_request(FUNC_DATA, 6'($urandom), 8'($urandom), 1'($urandom));
    end else begin
      rekey_and_prepare();
    end
  endtask

  // Result side: random stall before each result, with quiet stretches
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) take_stalls = !take_stalls;
      stall = take_stalls ? $urandom_range(0, 11) : 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // Request side and verdict
  initial begin
    logic [6:0]  phase_klen [6];
    logic [11:0] phase_drop [6];
    int p, phase_end;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= 3'd0;
    pwdata           <= 32'd0;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FUNC_NONE;
    req_ch.key_index <= 6'd0;
    req_ch.in_value  <= 8'd0;
    req_ch.last_byte <= 1'b0;
    key_loaded  = '0;
    key_len_now = KEYLEN_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unused function before any schedule, extreme bytes, defaults
    send_request(FUNC_NONE, 6'h3F, 8'hFF, 1'b1);
    send_request(FUNC_KEY, 6'h00, 8'hFF, 1'b0);
    send_request(FUNC_KEY, 6'h3F, 8'h00, 1'b1);
    send_request(FUNC_PREP, 6'h00, 8'h00, 1'b0);
    send_request(FUNC_DATA, 6'h00, 8'h00, 1'b0);
    send_request(FUNC_DATA, 6'h3F, 8'hFF, 1'b1);
    send_request(FUNC_DATA, 6'h15, 8'h5A, 1'b0);
    send_request(FUNC_NONE, 6'h00, 8'h00, 1'b0);
    // zero key length acts as one, no keystream drop
    drain_requests();
    write_register(REG_KEY_LENGTH, 32'd0);
    write_register(REG_DISCARD, 32'd0);
    send_request(FUNC_PREP, 6'h2A, 8'hA5, 1'b1);
    send_request(FUNC_DATA, 6'h00, 8'hA5, 1'b1);
    send_request(FUNC_KEY, 6'h01, 8'h80, 1'b0);
    // two-byte key, single dropped byte
    drain_requests();
    write_register(REG_KEY_LENGTH, 32'd2);
    write_register(REG_DISCARD, 32'd1);
    send_request(FUNC_PREP, 6'h00, 8'h00, 1'b1);
    send_request(FUNC_DATA, 6'h00, 8'h01, 1'b0);
    send_request(FUNC_DATA, 6'h00, 8'h80, 1'b1);

    // random phases across register settings, extremes first
    phase_klen = '{7'd64, 7'd127, 7'd1, 7'($urandom_range(2, 63)),
                   7'($urandom_range(1, 64)), 7'($urandom_range(0, 127))};
    phase_drop = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(0, 255)),
                   12'($urandom_range(0, 63)), 12'($urandom_range(0, 1023))};
    for (p = 0; p < 6; p++) begin
      drain_requests();
      write_register(REG_KEY_LENGTH, {25'd0, phase_klen[p]});
      write_register(REG_DISCARD, {20'd0, phase_drop[p]});
      phase_end = sent_requests + 150;
      rekey_and_prepare();
      while (sent_requests < phase_end) random_burst();
    end

    drain_requests();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mrc4_pkg.sv
rtl/mrc4_if.sv
rtl/mrc4_useq.sv
rtl/modified_rc4_stream_cipher_core.sv
rtl/mrc4_chk.sv
tb/sv/mrc4_cipher_checker.sv
tb/sv/modified_rc4_stream_cipher_core_test.sv
